@@ src/oas_pkg.sv @@
`default_nettype none
package oas_pkg;
  localparam int unsigned MaxWorkers = 16;
  localparam int unsigned MaxJobs = 16;
  localparam int unsigned EntryWidth = 16;
  localparam int unsigned TotalWidth = 21;
  localparam int unsigned CountWidth = 5;
  // potentials need entry width plus growth over at most 16 rows
  localparam int unsigned PotExtra = 10;

  localparam logic [1:0] RegWorkers = 2'd0;
  localparam logic [1:0] RegJobs = 2'd1;
  localparam logic [1:0] RegMaximize = 2'd2;
endpackage
`default_nettype wire

@@ src/oas_ram.sv @@
`default_nettype none
module oas_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ src/oas_cfg.sv @@
`default_nettype none
module oas_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [3:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output logic      [oas_pkg::CountWidth-1:0]  workers_o,
  output logic      [oas_pkg::CountWidth-1:0]  jobs_o,
  output logic                                 maximize_o
);
  import oas_pkg::*;

  logic [CountWidth-1:0] workers_q, jobs_q;
  logic                  max_q;
  logic                  wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      workers_q <= CountWidth'(16);
      jobs_q    <= CountWidth'(16);
      max_q     <= 1'b0;
    end else if (wr && paddr[1:0] == 2'd0) begin
      case (paddr[3:2])
        RegWorkers:  workers_q <= pwdata[CountWidth-1:0];
        RegJobs:     jobs_q    <= pwdata[CountWidth-1:0];
        RegMaximize: max_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      RegWorkers:  prdata = 32'(workers_q);
      RegJobs:     prdata = 32'(jobs_q);
      RegMaximize: prdata = 32'(max_q);
      default:     prdata = '0;
    endcase
  end

  assign workers_o  = workers_q;
  assign jobs_o     = jobs_q;
  assign maximize_o = max_q;
endmodule
`default_nettype wire

@@ src/optimal_assignment_solver_unit.sv @@
// Load: one item per cycle into the matrix memory while in the load state; the
// item carrying tlast starts a solve, or a size error result if workers exceed
// jobs. Solve: a scan for the largest entry, a clear, then per worker a setup and
// path steps that each read one row, at most i steps for worker i, then augment.
// Results: each is built, then held until the sink takes it, one after another.
// Reset is asynchronous, active low; the matrix memory is not cleared.
`default_nettype none
module optimal_assignment_solver_unit #(
  parameter int unsigned MAX_WORKERS = oas_pkg::MaxWorkers,
  parameter int unsigned JOB_SLOTS   = oas_pkg::MaxJobs,
  parameter int unsigned ENTRY_WIDTH = oas_pkg::EntryWidth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [((ENTRY_WIDTH+7)/8)*8-1:0] s_axis_tdata_i, // cost_entry
  input  wire logic        s_axis_tlast_i,                      // last_entry
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o, // worker_index, job_index, optimal_total
  output logic             m_axis_tuser_o, // size_error
  output logic             m_axis_tlast_o, // last_result
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import oas_pkg::*;

  localparam int unsigned Depth = MAX_WORKERS * JOB_SLOTS;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RW = $clog2(MAX_WORKERS + 1);
  localparam int unsigned CW = $clog2(JOB_SLOTS + 1);
  localparam int unsigned WI = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned PW = ENTRY_WIDTH + PotExtra + 2;
  localparam int unsigned MW = 2 * ENTRY_WIDTH + 8;
  localparam int unsigned BW = ENTRY_WIDTH + CW + 1;

  localparam logic [3:0] StLoad = 4'd0, StScan = 4'd1, StInit = 4'd2,
    StWorker = 4'd3, StRowRd = 4'd4, StCol = 4'd5, StUpd = 4'd6,
    StAug = 4'd7, StMul = 4'd8, StEmit = 4'd9, StErr = 4'd10, StOut = 4'd11;

  logic [CountWidth-1:0] workers_cfg, jobs_cfg;
  logic                  max_cfg;

  oas_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .workers_o(workers_cfg), .jobs_o(jobs_cfg), .maximize_o(max_cfg)
  );

  logic [3:0] st_q;
  logic [AW:0] pos_q;
  logic [AW:0] addr_q;
  logic [CW-1:0] n_q, m_q, j_q, cur_q, next_q;
  logic [RW-1:0] i_q, row_q;
  logic          mx_q, rd_pend_q;
  logic signed [ENTRY_WIDTH-1:0] big_q;
  logic signed [PW-1:0] u_q [MAX_WORKERS+1];
  logic signed [PW-1:0] v_q [JOB_SLOTS+1];
  logic signed [PW:0]   ms_q [JOB_SLOTS+1];
  logic signed [PW:0]   delta_q;
  logic [RW-1:0] own_q [JOB_SLOTS+1];
  logic [CW-1:0] way_q [JOB_SLOTS+1];
  logic [JOB_SLOTS:0] vis_q;
  logic [RW-1:0] asg_q [MAX_WORKERS];
  logic signed [MW-1:0] tot_q;
  logic [RW-1:0] oi_q;

  logic ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic signed [ENTRY_WIDTH-1:0] ram_rd;

  oas_ram #(.Width(ENTRY_WIDTH), .Depth(Depth)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa),
    .wdata_i(s_axis_tdata_i[ENTRY_WIDTH-1:0]), .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  logic in_acc, out_acc;
  assign s_axis_tready_o = (st_q == StLoad);
  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;
  assign ram_we = in_acc && pos_q < (AW+1)'(Depth);
  assign ram_wa = pos_q[AW-1:0];
  assign ram_ra = addr_q[AW-1:0];

  logic [CountWidth-1:0] n_c, m_c;
  always_comb begin
    n_c = (workers_cfg == '0) ? CountWidth'(1) :
          (32'(workers_cfg) > MAX_WORKERS) ? CountWidth'(MAX_WORKERS) : workers_cfg;
    m_c = (jobs_cfg == '0) ? CountWidth'(1) :
          (32'(jobs_cfg) > JOB_SLOTS) ? CountWidth'(JOB_SLOTS) : jobs_cfg;
  end

  // slack of (row_q, j_q) from the data read last cycle
  logic signed [PW:0] cellv, slack, ms_new;
  always_comb begin
    cellv = mx_q ? (PW+1)'(big_q) - (PW+1)'(ram_rd) : (PW+1)'(ram_rd);
    slack = cellv - (PW+1)'(u_q[row_q]) - (PW+1)'(v_q[j_q]);
    ms_new = (slack < ms_q[j_q]) ? slack : ms_q[j_q];
  end

  localparam logic signed [PW:0] Inf = {2'b01, {(PW-1){1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad;
      pos_q <= '0;
      m_axis_tvalid_o <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      case (st_q)
        StLoad: if (in_acc) begin
          if (ram_we) pos_q <= pos_q + 1'b1;
          if (s_axis_tlast_i) begin
            n_q <= CW'(n_c); m_q <= CW'(m_c); mx_q <= max_cfg;
            pos_q <= '0;
            big_q <= {1'b1, {(ENTRY_WIDTH-1){1'b0}}};
            addr_q <= '0; rd_pend_q <= 1'b0;
            st_q <= (n_c > m_c) ? StErr : StScan;
          end
        end
        StScan: begin
          if (rd_pend_q && ram_rd > big_q) big_q <= ram_rd;
          if (addr_q == (AW+1)'(n_q) * (AW+1)'(m_q)) begin
            rd_pend_q <= 1'b0; st_q <= StInit;
          end else begin
            addr_q <= addr_q + 1'b1; rd_pend_q <= 1'b1;
          end
        end
        StInit: begin
          for (int k = 0; k <= MAX_WORKERS; k++) u_q[k] <= '0;
          for (int k = 0; k <= JOB_SLOTS; k++) begin
            v_q[k] <= '0; own_q[k] <= '0; way_q[k] <= '0;
          end
          i_q <= RW'(1); st_q <= StWorker;
        end
        StWorker: begin
          for (int k = 0; k <= JOB_SLOTS; k++) ms_q[k] <= Inf;
          vis_q <= '0; own_q[0] <= i_q; cur_q <= '0; st_q <= StRowRd;
        end
        StRowRd: begin
          vis_q[cur_q] <= 1'b1;
          row_q <= own_q[cur_q];
          j_q <= CW'(1); delta_q <= Inf; next_q <= '0;
          addr_q <= (AW+1)'(own_q[cur_q] - 1'b1) * (AW+1)'(m_q);
          rd_pend_q <= 1'b0; st_q <= StCol;
        end
        StCol: begin
          // read issued at addr_q this cycle, evaluate the next
          if (!rd_pend_q) begin
            rd_pend_q <= 1'b1;
          end else begin
            rd_pend_q <= 1'b0;
            if (!vis_q[j_q]) begin
              ms_q[j_q] <= ms_new;
              if (slack < ms_q[j_q]) way_q[j_q] <= cur_q;
              if (ms_new < delta_q) begin
                delta_q <= ms_new; next_q <= j_q;
              end
            end
            addr_q <= addr_q + 1'b1;
            if (j_q == m_q) st_q <= StUpd;
            else j_q <= j_q + 1'b1;
          end
        end
        StUpd: begin
          for (int k = 0; k <= JOB_SLOTS; k++) begin
            if (k <= 32'(m_q)) begin
              if (vis_q[k]) begin
                v_q[k] <= v_q[k] - PW'(delta_q);
              end else begin
                ms_q[k] <= ms_q[k] - delta_q;
              end
            end
          end
          // each row owns at most one visited column
          for (int r = 0; r <= MAX_WORKERS; r++) begin
            logic hit;
            hit = 1'b0;
            for (int k = 0; k <= JOB_SLOTS; k++)
              if (k <= 32'(m_q) && vis_q[k] && own_q[k] == RW'(r)) hit = 1'b1;
            if (hit) u_q[r] <= u_q[r] + PW'(delta_q);
          end
          cur_q <= next_q;
          st_q <= (own_q[next_q] != '0) ? StRowRd : StAug;
        end
        StAug: begin
          own_q[cur_q] <= own_q[way_q[cur_q]];
          cur_q <= way_q[cur_q];
          if (way_q[cur_q] == '0) begin
            if (i_q == RW'(n_q)) st_q <= StMul;
            else begin
              i_q <= i_q + 1'b1; st_q <= StWorker;
            end
          end
        end
        StMul: begin
          tot_q <= mx_q ? MW'(BW'(big_q) * BW'(signed'({1'b0, n_q}))) + MW'(v_q[0])
                        : -MW'(v_q[0]);
          for (int k = 1; k <= JOB_SLOTS; k++)
            if (own_q[k] != '0 && k <= 32'(m_q))
              asg_q[WI'(own_q[k] - 1'b1)] <= RW'(k - 1);
          oi_q <= '0; st_q <= StEmit;
        end
        StEmit: begin
          m_axis_tvalid_o <= 1'b1;
          m_axis_tdata_o <= {3'b0, TotalWidth'(tot_q), 4'(asg_q[WI'(oi_q)]), 4'(oi_q)};
          m_axis_tuser_o <= 1'b0;
          m_axis_tlast_o <= (oi_q == RW'(n_q - 1'b1));
          st_q <= StOut;
        end
        StErr: begin
          m_axis_tvalid_o <= 1'b1; m_axis_tdata_o <= '0;
          m_axis_tuser_o <= 1'b1; m_axis_tlast_o <= 1'b1;
          st_q <= StOut;
        end
        StOut: if (out_acc) begin
          m_axis_tvalid_o <= 1'b0;
          if (m_axis_tlast_o) st_q <= StLoad;
          else begin
            oi_q <= oi_q + 1'b1; st_q <= StEmit;
          end
        end
        default: st_q <= StLoad;
      endcase
    end
  end

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni) (st_q != StLoad) |-> !s_axis_tready_o;
  endproperty
  assert property (p_no_accept_busy) else $error("item accepted while solving");

  property p_out_only_emit;
    @(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid_o |-> (st_q == StOut);
  endproperty
  assert property (p_out_only_emit) else $error("result outside output phase");

  property p_err_last;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o;
  endproperty
  assert property (p_err_last) else $error("error result not final");
endmodule
`default_nettype wire
